// ----- rtl/core/rnwc_pkg.sv -----
// ---------------------------------------------------------------------------
// rnwc_pkg: shared types and constants
// Verdict codes, register map, reset values and the slot/bounds structs used
// by the cell ring and the match unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rnwc_pkg;

   localparam int TIME_W  = 64;
   localparam int NONCE_W = 64;
   localparam int WIN_W   = 32;
   localparam int SKEW_W  = 16;
   localparam int VERD_W  = 2;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [VERD_W-1:0] VERDICT_OK        = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_FUTURE    = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_STALE     = 2'd2;
   localparam logic [VERD_W-1:0] VERDICT_DUPLICATE = 2'd3;

   // register select is address bit 2 (registers sit at 4*i)
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_SKEW   = 1'b1;

   localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd30000;
   localparam logic [SKEW_W-1:0] SKEW_RESET   = 16'd200;

   typedef struct packed {
      logic [NONCE_W-1:0] nonce;
      logic [TIME_W-1:0]  stamp;
   } slot_type;

   // per-request constants the match unit compares each slot against
   typedef struct packed {
      logic [NONCE_W-1:0] nonce;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  live_low;
      logic               all_live;
   } bounds_type;

endpackage

`default_nettype wire

// ----- rtl/core/rnwc_cell.sv -----
// ---------------------------------------------------------------------------
// rnwc_cell: one slot of the nonce ring
// Holds one nonce and its timestamp plus an occupied flag; on shift it takes
// the contents of its upstream neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module rnwc_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift,
   input  wire                 valid_in,
   input  rnwc_pkg::slot_type  slot_in,
   output logic                valid_out,
   output rnwc_pkg::slot_type  slot_out
);
   import rnwc_pkg::*;

   logic     valid_ff;
   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         slot_ff <= slot_in;
      end
   end

   assign valid_out = valid_ff;
   assign slot_out  = slot_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rnwc_match.sv -----
// ---------------------------------------------------------------------------
// rnwc_match: slot comparator
// Flags a slot that is occupied, holds the request nonce (nonzero) and is
// still live against the current time.
// ---------------------------------------------------------------------------
`default_nettype none

module rnwc_match (
   input  wire                  slot_valid,
   input  rnwc_pkg::slot_type   slot,
   input  rnwc_pkg::bounds_type bounds,
   output logic                 hit
);
   import rnwc_pkg::*;

   logic same_nonce;
   logic live;

   always_comb begin
      same_nonce = (slot.nonce != '0) && (slot.nonce == bounds.nonce);
      // future stamps are live; otherwise stamp >= now - window (all live if that underflows)
      live = (slot.stamp > bounds.now) || bounds.all_live ||
             (slot.stamp >= bounds.live_low);
      hit  = slot_valid && same_nonce && live;
   end

endmodule

`default_nettype wire

// ----- rtl/core/replay_nonce_window_check_top.sv -----
// ---------------------------------------------------------------------------
// replay_nonce_window_check_top: token replay and freshness check
// Rejects future-dated, stale and replayed tokens; records accepted nonces.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one verdict comes
// back on rsp_verdict with a one-cycle rsp_valid strobe that the receiver
// must take as it comes. A token rejected on its timestamp gets its verdict
// after the CHECK and JUDGE states; any other token walks the whole ring of
// RING_DEPTH cells past a single comparator before its verdict comes, and
// the block stays busy until then, so it takes no new request before it is
// through with the last one. Accepted tokens enter the ring at the first
// cell and push out the oldest entry. Reset empties the ring by clearing
// every cell's occupied flag.
// ---------------------------------------------------------------------------
`default_nettype none

module replay_nonce_window_check_top #(
   parameter int RING_DEPTH = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [rnwc_pkg::TIME_W-1:0]      req_current_time,
   input  wire  [rnwc_pkg::TIME_W-1:0]      req_token_time,
   input  wire  [rnwc_pkg::NONCE_W-1:0]     req_token_nonce,
   output logic                             rsp_valid,
   output logic [rnwc_pkg::VERD_W-1:0]      rsp_verdict,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [rnwc_pkg::ADDR_W-1:0]      paddr,
   input  wire  [rnwc_pkg::DATA_W-1:0]      pwdata,
   output logic [rnwc_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import rnwc_pkg::*;

   localparam int CNT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RING_DEPTH - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_JUDGE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // configuration
   logic [WIN_W-1:0]  window_ff;
   logic [SKEW_W-1:0] skew_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         skew_ff   <= SKEW_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_WINDOW: window_ff <= pwdata;
            REG_SKEW:   skew_ff   <= pwdata[SKEW_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WINDOW: prdata = window_ff;
         REG_SKEW:   prdata = {{(DATA_W-SKEW_W){1'b0}}, skew_ff};
         default:    prdata = '0;
      endcase
   end

   // control and request registers
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               dup_ff, dup_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VERD_W-1:0]  verdict_ff, verdict_in;
   logic [TIME_W-1:0]  now_ff, ttime_ff;
   logic [NONCE_W-1:0] nonce_ff;
   logic [TIME_W:0]    low_ff, high_ff;
   logic               take;

   assign take = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff   <= req_current_time;
         ttime_ff <= req_token_time;
         nonce_ff <= req_token_nonce;
      end
      if (state_ff == ST_CHECK) begin
         // low bound of the freshness window; top bit set means it underflowed
         low_ff  <= {1'b0, now_ff} - {{(TIME_W+1-WIN_W){1'b0}}, window_ff};
         high_ff <= {1'b0, now_ff} + {{(TIME_W+1-SKEW_W){1'b0}}, skew_ff};
      end
   end

   // cell ring
   logic               shift;
   logic               insert;
   logic [RING_DEPTH-1:0] cell_valid;
   slot_type           cell_slot [RING_DEPTH];
   logic               head_valid;
   slot_type           head_slot;
   slot_type           new_slot;

   assign insert   = (state_ff == ST_DONE) && !dup_ff;
   assign shift    = (state_ff == ST_SCAN) || insert;
   assign new_slot = '{nonce: nonce_ff, stamp: ttime_ff};

   // during the scan the ring rotates; on insert the new entry enters
   always_comb begin
      if (insert) begin
         head_valid = 1'b1;
         head_slot  = new_slot;
      end else begin
         head_valid = cell_valid[RING_DEPTH-1];
         head_slot  = cell_slot[RING_DEPTH-1];
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            rnwc_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .shift     (shift),
               .valid_in  (head_valid),
               .slot_in   (head_slot),
               .valid_out (cell_valid[gi]),
               .slot_out  (cell_slot[gi])
            );
         end else begin : g_next
            rnwc_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .shift     (shift),
               .valid_in  (cell_valid[gi-1]),
               .slot_in   (cell_slot[gi-1]),
               .valid_out (cell_valid[gi]),
               .slot_out  (cell_slot[gi])
            );
         end
      end
   endgenerate

   // comparator at the ring's tail
   bounds_type bounds;
   logic       hit;

   assign bounds = '{nonce:    nonce_ff,
                     now:      now_ff,
                     live_low: low_ff[TIME_W-1:0],
                     all_live: low_ff[TIME_W]};

   rnwc_match u_match (
      .slot_valid (cell_valid[RING_DEPTH-1]),
      .slot       (cell_slot[RING_DEPTH-1]),
      .bounds     (bounds),
      .hit        (hit)
   );

   // sequencer
   logic too_future;
   logic too_old;

   assign too_future = {1'b0, ttime_ff} > high_ff;
   assign too_old    = !low_ff[TIME_W] && (ttime_ff < low_ff[TIME_W-1:0]);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dup_in       = dup_ff;
      rsp_valid_in = 1'b0;
      verdict_in   = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            cnt_in = '0;
            dup_in = 1'b0;
            if (too_future) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               verdict_in   = VERDICT_FUTURE;
            end else if (too_old) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               verdict_in   = VERDICT_STALE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            dup_in = dup_ff || hit;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            verdict_in   = dup_ff ? VERDICT_DUPLICATE : VERDICT_OK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rnwc_checker.sv -----
// ---------------------------------------------------------------------------
// rnwc_checker: port-level checks
// Watches the request, result and register ports of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rnwc_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid,
   input wire pready
);

   // a taken request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // the result strobe comes with the block idle again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // one strobe per request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // no result right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result too early");

   assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind replay_nonce_window_check_top rnwc_checker u_rnwc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);

`default_nettype wire
